/* hdl/hff_pkg.sv */
// Shared types, constants and helpers for the hex field formatter.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package hff_pkg;

    // Field limits
    localparam int MAX_WIDTH  = 64;
    localparam int VALUE_BITS = 32;
    localparam int VAL_IN_W   = 32;
    localparam int PREC_MAX   = MAX_WIDTH - 2;

    // Digit datapath sizing
    localparam int USED_BITS  = (VALUE_BITS < VAL_IN_W) ? VALUE_BITS : VAL_IN_W;
    localparam int NIB_COUNT  = (USED_BITS + 3) / 4;
    localparam int VAL_W      = NIB_COUNT * 4;
    localparam int NIB_W      = (NIB_COUNT > 1) ? $clog2(NIB_COUNT) : 1;
    localparam int CNT_W      = 7;

    // Queue between front and back
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = 1;
    localparam int Q_CNT_W    = 2;

    // Character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_A_UP  = 8'h41;

    typedef struct packed {
        logic [VAL_IN_W-1:0] value;
        logic [6:0]          field_width;
        logic                has_precision;
        logic [5:0]          min_digits;
        logic                alt_form;
        logic                zero_pad;
        logic                left_align;
        logic                upper_case;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       is_last;
        logic [6:0] total_chars;
    } t_out_item;

    // Classified item: segment boundaries as running character positions
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             upper;
        logic [CNT_W-1:0] end_lead;
        logic [CNT_W-1:0] end_prefix;
        logic [CNT_W-1:0] end_zeros;
        logic [CNT_W-1:0] end_digits;
        logic [CNT_W-1:0] total;
    } t_desc;

    // Map one nibble to its ASCII hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic up);
        logic [7:0] base;
        begin
            base = up ? CH_A_UP : CH_A_LO;
            if (nib < 4'd10) begin
                hex_char = CH_ZERO + {4'd0, nib};
            end else begin
                hex_char = base + {4'd0, nib} - 8'd10;
            end
        end
    endfunction

endpackage

`default_nettype wire

/* hdl/hff_front.sv */
// Front stage: accepts input transactions and classifies them into segment boundaries.
// Depends on hff_pkg.
`default_nettype none

module hff_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_stall,
    input  hff_pkg::t_in_item i_data,
    output logic             o_push,
    input  wire              i_full,
    output hff_pkg::t_desc   o_desc
);
    import hff_pkg::*;

    logic             r_valid;
    t_desc            r_desc;
    t_desc            n_desc;

    logic [VAL_W-1:0] v;
    logic [CNT_W-1:0] w;
    logic [5:0]       p6;
    logic [CNT_W-1:0] prec;
    logic [CNT_W-1:0] ndig;
    logic [CNT_W-1:0] digits;
    logic [CNT_W-1:0] body;
    logic [CNT_W-1:0] pad;
    logic [CNT_W-1:0] lead;
    logic [CNT_W-1:0] zeros;
    logic [CNT_W-1:0] trail;
    logic [CNT_W-1:0] pre2;
    logic             vz;
    logic             blank;
    logic             accept;

    // Classify the incoming item
    always_comb begin
        v = '0;
        v[USED_BITS-1:0] = i_data.value[USED_BITS-1:0];
        vz = (v == '0);

        w  = (i_data.field_width > CNT_W'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH)
                                                      : i_data.field_width;
        p6 = (i_data.min_digits > 6'(PREC_MAX)) ? 6'(PREC_MAX) : i_data.min_digits;
        prec = i_data.has_precision ? {1'b0, p6} : '0;

        // Count significant hex digits, at least one
        ndig = CNT_W'(1);
        for (int k = 1; k < NIB_COUNT; k++) begin
            if (v[k*4 +: 4] != 4'd0) begin
                ndig = CNT_W'(k + 1);
            end
        end

        blank  = i_data.has_precision && (prec == '0) && vz;
        pre2   = (i_data.alt_form && !vz) ? CNT_W'(2) : '0;
        digits = (prec > ndig) ? prec : ndig;
        body   = digits + pre2;
        pad    = (w > body) ? (w - body) : '0;

        lead  = (!i_data.left_align && (!i_data.zero_pad || i_data.has_precision))
                ? pad : '0;
        zeros = ((!i_data.left_align && i_data.zero_pad && !i_data.has_precision)
                 ? pad : '0) + ((prec > ndig) ? (prec - ndig) : '0);
        trail = i_data.left_align ? pad : '0;

        // Zero value with precision zero prints only the width in spaces
        if (blank) begin
            lead  = w;
            pre2  = '0;
            zeros = '0;
            ndig  = '0;
            trail = '0;
        end

        n_desc.value      = v;
        n_desc.upper      = i_data.upper_case;
        n_desc.end_lead   = lead;
        n_desc.end_prefix = lead + pre2;
        n_desc.end_zeros  = lead + pre2 + zeros;
        n_desc.end_digits = lead + pre2 + zeros + ndig;
        n_desc.total      = lead + pre2 + zeros + ndig + trail;
    end

    assign o_stall = r_valid && i_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_valid && !i_full;
    assign o_desc  = r_desc;

    // Hold the classified transaction until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_desc <= n_desc;
        end
    end

endmodule

`default_nettype wire

/* hdl/hff_queue.sv */
// Two-entry queue that decouples the classifier from the character sequencer.
// Depends on hff_pkg.
`default_nettype none

module hff_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  hff_pkg::t_desc  i_desc,
    output logic            o_full,
    input  wire             i_pop,
    output logic            o_empty,
    output hff_pkg::t_desc  o_desc
);
    import hff_pkg::*;

    t_desc              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_desc  = r_mem[r_rd_ptr];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue pop while empty");
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_W'(Q_DEPTH))
        else $error("queue occupancy past depth");
`endif

endmodule

`default_nettype wire

/* hdl/hff_back.sv */
// Back stage: walks one classified item and emits a character per cycle unless the output stalls.
// Depends on hff_pkg.
`default_nettype none

module hff_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_empty,
    output logic              o_pop,
    input  hff_pkg::t_desc    i_desc,
    output logic              o_valid,
    input  wire               i_stall,
    output hff_pkg::t_out_item o_data
);
    import hff_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } t_state;

    t_state           r_state;
    t_state           n_state;
    t_desc            r_desc;
    logic [CNT_W-1:0] r_pos;
    logic             r_o_valid;
    t_out_item        r_o_data;

    logic             slot_free;
    logic             emit;
    logic             last;
    logic [CNT_W-1:0] dig_off;
    logic [NIB_W-1:0] nib_idx;
    logic [7:0]       ch;

    assign slot_free = !r_o_valid || !i_stall;
    assign o_pop     = (r_state == S_IDLE) && !i_empty;
    assign emit      = (r_state == S_EMIT) && slot_free;
    assign last      = (r_pos + 1'b1) == r_desc.total;

    // Pick the character at the current position
    always_comb begin
        dig_off = r_desc.end_digits - r_pos - 1'b1;
        nib_idx = dig_off[NIB_W-1:0];
        if (r_pos < r_desc.end_lead) begin
            ch = CH_SPACE;
        end else if (r_pos < r_desc.end_prefix) begin
            if (r_pos == r_desc.end_lead) begin
                ch = CH_ZERO;
            end else begin
                ch = r_desc.upper ? CH_X_UP : CH_X_LO;
            end
        end else if (r_pos < r_desc.end_zeros) begin
            ch = CH_ZERO;
        end else if (r_pos < r_desc.end_digits) begin
            ch = hex_char(r_desc.value[nib_idx*4 +: 4], r_desc.upper);
        end else begin
            ch = CH_SPACE;
        end
    end

    // Sequence: take an item, then step through its characters
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_pop && (i_desc.total != '0)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit && last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Load item, advance position, fill output register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_desc <= i_desc;
            r_pos  <= '0;
        end else if (emit) begin
            r_pos <= r_pos + 1'b1;
        end
        if (emit) begin
            r_o_data.out_char    <= ch;
            r_o_data.is_last     <= last;
            r_o_data.total_chars <= last ? r_desc.total : '0;
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

`ifndef SYNTHESIS
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_pos < r_desc.total))
        else $error("character position past item end");
    a_total_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.is_last == (o_data.total_chars != '0)))
        else $error("total count not tied to last character");
    a_done_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && last) |=> (r_state == S_IDLE))
        else $error("sequencer did not finish after last character");
`endif

endmodule

`default_nettype wire

/* hdl/hex_field_formatter.sv */
// Hex field formatter: printf %x/%X conversion, one character per output transaction.
// An accepted item is held in the front stage register, then in a queue entry, then in
// the sequencer's item register; each character is registered at the output. The
// sequencer keeps an item until its last character goes out; empty items are dropped.
// A two-entry queue lets the next item be accepted and classified meanwhile.
// Reset: synchronous active-low i_rst_n empties the queue and clears all valid flags.
`default_nettype none

module hex_field_formatter (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  hff_pkg::t_in_item   i_data,
    output logic                o_valid,
    input  wire                 i_stall,
    output hff_pkg::t_out_item  o_data
);
    import hff_pkg::*;

    logic  push;
    logic  pop;
    logic  full;
    logic  empty;
    t_desc front_desc;
    t_desc queue_desc;

    hff_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_push  (push),
        .i_full  (full),
        .o_desc  (front_desc)
    );

    hff_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (front_desc),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_desc  (queue_desc)
    );

    hff_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .o_pop   (pop),
        .i_desc  (queue_desc),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

`default_nettype wire
